// ----- hw/rtl/sha1_bsh_pkg.sv -----
package sha1_bsh_pkg;

  localparam int WORD_CNT  = 5;
  localparam int ROUNDS    = 80;
  localparam int ROUND_W   = 7;
  localparam int IDX_W     = 3;
  localparam int POS_W     = 6;
  localparam int COUNT_W   = 61;
  localparam int LINE_LEN  = 16;

  localparam logic [POS_W-1:0]   POS_LAST    = 6'd63;
  localparam logic [POS_W-1:0]   POS_LEN     = 6'd56;
  localparam logic [IDX_W-1:0]   IDX_LAST    = 3'd4;
  localparam logic [ROUND_W-1:0] ROUND_LAST  = 7'd79;
  localparam logic [ROUND_W-1:0] ROUND_PH1   = 7'd20;
  localparam logic [ROUND_W-1:0] ROUND_PH2   = 7'd40;
  localparam logic [ROUND_W-1:0] ROUND_PH3   = 7'd60;
  localparam logic [7:0]         PAD_BYTE    = 8'h80;

  localparam logic [31:0] H_INIT [WORD_CNT] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_PH0 = 32'h5A827999;
  localparam logic [31:0] K_PH1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_PH2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_PH3 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_CINIT,
    ST_ROUND,
    ST_CFIN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_PAD80,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_t;

  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR1,
    PH_MAJ,
    PH_PAR2
  } phase_t;

  typedef struct packed {
    logic             byte_we;
    byte_sel_t        byte_sel;
    logic             count_inc;
    logic             comp_init;
    logic             round_en;
    phase_t           phase;
    logic             comp_fin;
    logic             finish;
    logic [IDX_W-1:0] word_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
  } dp_stat_t;

  function automatic logic [31:0] round_k(phase_t ph);
    logic [31:0] k;
    unique case (ph)
      PH_CH:   k = K_PH0;
      PH_PAR1: k = K_PH1;
      PH_MAJ:  k = K_PH2;
      PH_PAR2: k = K_PH3;
      default: k = K_PH0;
    endcase
    return k;
  endfunction

endpackage

// ----- hw/rtl/sha1_bsh_dp.sv -----
module sha1_bsh_dp
  import sha1_bsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  in_byte,
  output dp_stat_t    stat,
  output logic [31:0] digest
);

  logic [31:0]        h_r [WORD_CNT];
  logic [31:0]        w_r [LINE_LEN];
  logic [23:0]        acc_r;
  logic [COUNT_W-1:0] count_r;
  logic [POS_W-1:0]   pos_r;
  logic [31:0]        a_r, b_r, c_r, d_r, e_r;

  logic [63:0] len_bits;
  logic [7:0]  byte_val;
  logic [31:0] w_mix;
  logic [31:0] w_new;
  logic [31:0] f_val;
  logic [31:0] t_val;
  logic        word_done;

  assign len_bits = {count_r, 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      BSEL_DATA:  byte_val = in_byte;
      BSEL_PAD80: byte_val = PAD_BYTE;
      BSEL_ZERO:  byte_val = 8'h00;
      BSEL_LEN:   byte_val = len_bits[{~pos_r[2:0], 3'b000} +: 8];
      default:    byte_val = 8'h00;
    endcase
  end

  assign word_done = cmd.byte_we && (pos_r[1:0] == 2'b11);

  // Schedule taps on the sixteen-word line: oldest word sits at index 0.
  assign w_mix = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    case (cmd.phase)
      PH_CH:   f_val = (b_r & c_r) | (~b_r & d_r);
      PH_MAJ:  f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      default: f_val = b_r ^ c_r ^ d_r;
    endcase
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + round_k(cmd.phase) + w_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pos_r   <= '0;
    end else if (cmd.finish) begin
      count_r <= '0;
      pos_r   <= '0;
    end else begin
      if (cmd.count_inc) count_r <= count_r + 1'b1;
      if (cmd.byte_we)   pos_r   <= pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WORD_CNT; i++) h_r[i] <= H_INIT[i];
    end else if (cmd.finish) begin
      for (int i = 0; i < WORD_CNT; i++) h_r[i] <= H_INIT[i];
    end else if (cmd.comp_fin) begin
      h_r[0] <= h_r[0] + a_r;
      h_r[1] <= h_r[1] + b_r;
      h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r;
      h_r[4] <= h_r[4] + e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_we) acc_r <= {acc_r[15:0], byte_val};
    if (word_done || cmd.round_en) begin
      for (int i = 0; i < LINE_LEN - 1; i++) w_r[i] <= w_r[i+1];
      w_r[LINE_LEN-1] <= cmd.round_en ? w_new : {acc_r, byte_val};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.comp_init) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round_en) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  assign stat.pos = pos_r;
  assign digest   = h_r[cmd.word_idx];

endmodule

// ----- hw/rtl/sha1_bsh_ctrl.sv -----
module sha1_bsh_ctrl
  import sha1_bsh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_present,
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [IDX_W-1:0] out_idx,
  output logic             out_tlast,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd
);

  state_t             state_r, state_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               first_r, first_nxt;
  logic               len_ok_r, len_ok_nxt;
  logic               final_r, final_nxt;
  logic               pend_r, pend_nxt;
  logic               len_ok_cur;
  logic               in_fire;
  logic               out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // Once the 0x80 marker lands before byte 56, the length fits in this block.
  assign len_ok_cur = first_r ? (stat.pos < POS_LEN) : len_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      round_r  <= '0;
      idx_r    <= '0;
      first_r  <= 1'b0;
      len_ok_r <= 1'b0;
      final_r  <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      round_r  <= round_nxt;
      idx_r    <= idx_nxt;
      first_r  <= first_nxt;
      len_ok_r <= len_ok_nxt;
      final_r  <= final_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    round_nxt  = round_r;
    idx_nxt    = idx_r;
    first_nxt  = first_r;
    len_ok_nxt = len_ok_r;
    final_nxt  = final_r;
    pend_nxt   = pend_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    cmd.byte_sel = BSEL_DATA;
    cmd.word_idx = idx_r;
    if (round_r < ROUND_PH1)      cmd.phase = PH_CH;
    else if (round_r < ROUND_PH2) cmd.phase = PH_PAR1;
    else if (round_r < ROUND_PH3) cmd.phase = PH_MAJ;
    else                          cmd.phase = PH_PAR2;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          first_nxt  = in_tlast;
          len_ok_nxt = 1'b0;
          if (in_present) begin
            cmd.byte_we   = 1'b1;
            cmd.count_inc = 1'b1;
          end
          if (in_present && (stat.pos == POS_LAST)) begin
            pend_nxt  = in_tlast;
            state_nxt = ST_CINIT;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.byte_we = 1'b1;
        if (first_r)                                cmd.byte_sel = BSEL_PAD80;
        else if (len_ok_r && (stat.pos >= POS_LEN)) cmd.byte_sel = BSEL_LEN;
        else                                        cmd.byte_sel = BSEL_ZERO;
        first_nxt  = 1'b0;
        len_ok_nxt = len_ok_cur;
        if (stat.pos == POS_LAST) begin
          final_nxt  = len_ok_cur;
          len_ok_nxt = 1'b1;
          pend_nxt   = 1'b1;
          state_nxt  = ST_CINIT;
        end
      end
      ST_CINIT: begin
        cmd.comp_init = 1'b1;
        round_nxt     = '0;
        state_nxt     = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        round_nxt    = round_r + 1'b1;
        if (round_r == ROUND_LAST) state_nxt = ST_CFIN;
      end
      ST_CFIN: begin
        cmd.comp_fin = 1'b1;
        final_nxt    = 1'b0;
        pend_nxt     = 1'b0;
        idx_nxt      = '0;
        if (final_r)     state_nxt = ST_OUT;
        else if (pend_r) state_nxt = ST_PAD;
        else             state_nxt = ST_IDLE;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_fire) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == IDX_LAST) begin
            cmd.finish = 1'b1;
            idx_nxt    = '0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_idx   = idx_r;
  assign out_tlast = (idx_r == IDX_LAST);

endmodule

// ----- hw/rtl/sha1_byte_stream_hasher_top.sv -----
// SHA-1 hasher over a byte stream. Each input word may carry one message byte
// (in_tuser[0] set) and may end the message (in_tlast set); a word with
// in_tlast alone ends the message after the bytes already sent, so the empty
// message works too. Message bytes are taken one per cycle while no block is
// being compressed. Every 64th byte starts the compression, which runs one
// round per cycle in a single round unit (load, 80 rounds, chaining add),
// during which the input is held off. At end of message the pad bytes (0x80,
// zeros, 64-bit bit length) go into the buffer one per cycle, 64 - (length
// mod 64) bytes, or 64 more when fewer than nine bytes were free, each padded
// block followed by the compression. The digest then leaves as five 32-bit
// words, most significant first, out_tuser giving the word index and
// out_tlast marking the fifth; after that word is taken the hasher is back in
// its initial state.
module sha1_byte_stream_hasher_top
  import sha1_bsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha1_bsh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_present (in_tuser[0]),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_idx    (out_tuser),
    .out_tlast  (out_tlast),
    .stat       (stat),
    .cmd        (cmd)
  );

  sha1_bsh_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_byte (in_tdata),
    .stat    (stat),
    .digest  (out_tdata)
  );

endmodule
